@@ hw/rtl/bptb_pkg.sv @@
// Bracket pair table builder: shared types, constants and the symbol classifier.
// No dependencies.
package bptb_pkg;

  localparam int unsigned MaxLenDef     = 4096;
  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned NumClasses    = 30;
  localparam int unsigned ClsW          = 5;
  localparam int unsigned EnW           = 5;
  localparam int unsigned BufDepth      = 4;
  localparam int unsigned BufPtrW       = 2;
  localparam int unsigned BufCntW       = 3;

  localparam logic [EnW-1:0] EnableReset = 5'd1;

  localparam int unsigned EnRound  = 0;
  localparam int unsigned EnAngle  = 1;
  localparam int unsigned EnCurly  = 2;
  localparam int unsigned EnSquare = 3;
  localparam int unsigned EnLetter = 4;

  localparam logic [ClsW-1:0] ClsRound   = 5'd0;
  localparam logic [ClsW-1:0] ClsAngle   = 5'd1;
  localparam logic [ClsW-1:0] ClsCurly   = 5'd2;
  localparam logic [ClsW-1:0] ClsSquare  = 5'd3;
  localparam logic [ClsW-1:0] ClsLetter0 = 5'd4;

  localparam logic [7:0] ChRoundOpen   = 8'h28;
  localparam logic [7:0] ChRoundClose  = 8'h29;
  localparam logic [7:0] ChAngleOpen   = 8'h3C;
  localparam logic [7:0] ChAngleClose  = 8'h3E;
  localparam logic [7:0] ChCurlyOpen   = 8'h7B;
  localparam logic [7:0] ChCurlyClose  = 8'h7D;
  localparam logic [7:0] ChSquareOpen  = 8'h5B;
  localparam logic [7:0] ChSquareClose = 8'h5D;
  localparam logic [7:0] ChUpperFirst  = 8'd65;
  localparam logic [7:0] ChUpperEnd    = 8'd91;
  localparam logic [7:0] ChCaseGap     = 8'd32;

  localparam logic KindPair   = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP
  } op_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_UNMATCHED,
    ST_UNCLOSED,
    ST_TOO_LONG
  } status_e;

  typedef struct packed {
    logic            hit;
    logic            opens;
    logic [ClsW-1:0] cls;
  } cls_t;

  typedef struct packed {
    op_e             op;
    logic [ClsW-1:0] cls;
    logic            fin;
    logic            too_long;
  } ctl_t;

  function automatic cls_t classify(logic [7:0] sym, logic [EnW-1:0] en);
    cls_t r;
    logic [7:0] lo_first;
    logic [7:0] lo_end;
    r        = '0;
    lo_first = ChUpperFirst + ChCaseGap;
    lo_end   = ChUpperEnd + ChCaseGap;
    unique case (sym)
      ChRoundOpen: begin
        r.hit = en[EnRound]; r.opens = 1'b1; r.cls = ClsRound;
      end
      ChRoundClose: begin
        r.hit = en[EnRound]; r.cls = ClsRound;
      end
      ChAngleOpen: begin
        r.hit = en[EnAngle]; r.opens = 1'b1; r.cls = ClsAngle;
      end
      ChAngleClose: begin
        r.hit = en[EnAngle]; r.cls = ClsAngle;
      end
      ChCurlyOpen: begin
        r.hit = en[EnCurly]; r.opens = 1'b1; r.cls = ClsCurly;
      end
      ChCurlyClose: begin
        r.hit = en[EnCurly]; r.cls = ClsCurly;
      end
      ChSquareOpen: begin
        r.hit = en[EnSquare]; r.opens = 1'b1; r.cls = ClsSquare;
      end
      ChSquareClose: begin
        r.hit = en[EnSquare]; r.cls = ClsSquare;
      end
      default: begin
        if (en[EnLetter] && sym >= ChUpperFirst && sym < ChUpperEnd) begin
          r.hit   = 1'b1;
          r.opens = 1'b1;
          r.cls   = ClsW'(sym - ChUpperFirst) + ClsLetter0;
        end else if (en[EnLetter] && sym >= lo_first && sym < lo_end) begin
          r.hit = 1'b1;
          r.cls = ClsW'(sym - lo_first) + ClsLetter0;
        end
      end
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/bptb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bptb_ram #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/bptb_queue.sv @@
// Short FIFO between the classifier front end and the stack engine.
// No dependencies.
module bptb_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  output logic         valid_o,
  output logic [W-1:0] data_o,
  input  logic         pop_i
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  logic [W-1:0]    mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == Full);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/bptb_front.sv @@
// Front end: input handshake, position counter, class enable register, symbol classifier.
// Depends on bptb_pkg.
module bptb_front #(
  parameter int unsigned MAX_LEN = 4096,
  parameter int unsigned POS_W   = 13
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bptb_pkg::EnW-1:0]  class_enable_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                symbol_i,
  input  logic                      last_symbol_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output bptb_pkg::ctl_t            q_ctl_o,
  output logic [POS_W-1:0]          q_pos_o
);

  import bptb_pkg::*;

  localparam logic [POS_W-1:0] MaxPos = POS_W'(MAX_LEN);

  logic [EnW-1:0]   en_q;
  logic [POS_W-1:0] pos_q, pos_d, pos_inc;
  logic             accept;
  cls_t             cls;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i;
  assign accept      = in_valid_i && !q_full_i;
  assign q_push_o    = accept;
  assign q_pos_o     = pos_inc;

  always_comb begin
    pos_inc          = (pos_q <= MaxPos) ? pos_q + 1'b1 : pos_q;
    cls              = classify(symbol_i, en_q);
    q_ctl_o.cls      = cls.cls;
    q_ctl_o.fin      = last_symbol_i;
    q_ctl_o.too_long = (pos_inc > MaxPos);
    q_ctl_o.op       = OP_NONE;
    if (cls.hit && !q_ctl_o.too_long) begin
      q_ctl_o.op = cls.opens ? OP_PUSH : OP_POP;
    end
    pos_d = pos_q;
    if (accept) begin
      pos_d = last_symbol_i ? '0 : pos_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      en_q  <= EnableReset;
    end else begin
      pos_q <= pos_d;
      if (cfg_valid_i && cfg_ready_o) begin
        en_q <= class_enable_i;
      end
    end
  end

endmodule

@@ hw/rtl/bptb_back.sv @@
// Stack engine: class tops, link memory, error and open tracking, result buffer.
// Depends on bptb_pkg and bptb_ram.
module bptb_back #(
  parameter int unsigned MAX_LEN = 4096,
  parameter int unsigned POS_W   = 13,
  parameter int unsigned ADDR_W  = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  bptb_pkg::ctl_t      q_ctl_i,
  input  logic [POS_W-1:0]    q_pos_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                item_kind_o,
  output logic [POS_W-1:0]    open_pos_o,
  output logic [POS_W-1:0]    close_pos_o,
  output logic [1:0]          status_o,
  output logic                last_o
);

  import bptb_pkg::*;

  logic [POS_W-1:0]   tops_q [NumClasses];
  logic [POS_W-1:0]   tops_d [NumClasses];
  logic               pend_q, pend_d;
  logic [ClsW-1:0]    pend_cls_q, pend_cls_d;
  logic               err_q, err_d;
  logic [POS_W-1:0]   open_cnt_q, open_cnt_d;

  logic [POS_W-1:0]   ram_rdata, cur_top;
  logic               ram_we;
  logic               take, is_push, is_pop, pair_ok, pop_fail, fin;
  status_e            st;

  logic               r_kind_q   [BufDepth];
  logic [POS_W-1:0]   r_open_q   [BufDepth];
  logic [POS_W-1:0]   r_close_q  [BufDepth];
  status_e            r_status_q [BufDepth];
  logic               r_last_q   [BufDepth];
  logic [BufPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, slot1;
  logic [BufCntW-1:0] cnt_q, cnt_d;
  logic               out_pop;

  bptb_ram #(
    .W     (POS_W),
    .DEPTH (MAX_LEN + 1)
  ) u_link (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (q_pos_i[ADDR_W-1:0]),
    .wdata_i (cur_top),
    .raddr_i (cur_top[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign take     = q_valid_i && (cnt_q <= BufCntW'(BufDepth - 2));
  assign q_pop_o  = take;
  assign cur_top  = (pend_q && pend_cls_q == q_ctl_i.cls) ? ram_rdata : tops_q[q_ctl_i.cls];
  assign is_push  = take && q_ctl_i.op == OP_PUSH;
  assign is_pop   = take && q_ctl_i.op == OP_POP;
  assign pair_ok  = is_pop && cur_top != '0;
  assign pop_fail = is_pop && cur_top == '0;
  assign fin      = take && q_ctl_i.fin;
  assign ram_we   = is_push;

  always_comb begin
    tops_d     = tops_q;
    pend_d     = 1'b0;
    pend_cls_d = pend_cls_q;
    err_d      = err_q | pop_fail;
    open_cnt_d = open_cnt_q;
    if (pend_q) begin
      tops_d[pend_cls_q] = ram_rdata;
    end
    if (is_push) begin
      tops_d[q_ctl_i.cls] = q_pos_i;
      open_cnt_d          = open_cnt_q + 1'b1;
    end
    if (pair_ok) begin
      pend_d     = 1'b1;
      pend_cls_d = q_ctl_i.cls;
      open_cnt_d = open_cnt_q - 1'b1;
    end
    priority if (q_ctl_i.too_long) begin
      st = ST_TOO_LONG;
    end else if (err_d) begin
      st = ST_UNMATCHED;
    end else if (open_cnt_d != '0) begin
      st = ST_UNCLOSED;
    end else begin
      st = ST_OK;
    end
    if (fin) begin
      for (int k = 0; k < NumClasses; k++) begin
        tops_d[k] = '0;
      end
      pend_d     = 1'b0;
      err_d      = 1'b0;
      open_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumClasses; k++) begin
        tops_q[k] <= '0;
      end
      pend_q     <= 1'b0;
      pend_cls_q <= '0;
      err_q      <= 1'b0;
      open_cnt_q <= '0;
    end else begin
      tops_q     <= tops_d;
      pend_q     <= pend_d;
      pend_cls_q <= pend_cls_d;
      err_q      <= err_d;
      open_cnt_q <= open_cnt_d;
    end
  end

  // result buffer, up to two writes and one read per cycle
  assign out_pop     = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign item_kind_o = r_kind_q[rd_ptr_q];
  assign open_pos_o  = r_open_q[rd_ptr_q];
  assign close_pos_o = r_close_q[rd_ptr_q];
  assign status_o    = r_status_q[rd_ptr_q];
  assign last_o      = r_last_q[rd_ptr_q];
  assign slot1       = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + BufPtrW'(pair_ok) + BufPtrW'(fin);
    rd_ptr_d = rd_ptr_q + BufPtrW'(out_pop);
    cnt_d    = cnt_q + BufCntW'(pair_ok) + BufCntW'(fin) - BufCntW'(out_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_ok) begin
      r_kind_q[wr_ptr_q]   <= KindPair;
      r_open_q[wr_ptr_q]   <= cur_top;
      r_close_q[wr_ptr_q]  <= q_pos_i;
      r_status_q[wr_ptr_q] <= ST_OK;
      r_last_q[wr_ptr_q]   <= 1'b0;
      if (fin) begin
        r_kind_q[slot1]   <= KindStatus;
        r_open_q[slot1]   <= '0;
        r_close_q[slot1]  <= '0;
        r_status_q[slot1] <= st;
        r_last_q[slot1]   <= 1'b1;
      end
    end else if (fin) begin
      r_kind_q[wr_ptr_q]   <= KindStatus;
      r_open_q[wr_ptr_q]   <= '0;
      r_close_q[wr_ptr_q]  <= '0;
      r_status_q[wr_ptr_q] <= st;
      r_last_q[wr_ptr_q]   <= 1'b1;
    end
  end

  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= BufCntW'(BufDepth))
    else $error("result buffer overflow");

  a_fin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> open_cnt_q == '0 && !pend_q && !err_q)
    else $error("structure state not cleared after last symbol");

  a_pair_emitted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_ok |=> out_valid_o)
    else $error("matched close produced no result");

  a_pop_has_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_ok |-> open_cnt_q != '0)
    else $error("pop with no open bracket counted");

endmodule

@@ hw/rtl/bracket_pair_table_builder_unit.sv @@
// An accepted symbol is registered in the queue and its results in the result buffer.
// Throughput: one symbol per cycle unless stalled; the stack engine pops one queue entry
// per cycle while the result buffer has room, and forwards the link memory read for a pop
// into the next cycle's class top; a last symbol that closes a pair yields two results.
// Reset (async, active low) empties all stacks, clears position and error, sets enable
// to round brackets only; the link memory is not cleared and needs no clearing pass.
module bracket_pair_table_builder_unit #(
  parameter int unsigned MAX_LEN     = bptb_pkg::MaxLenDef,
  parameter int unsigned QUEUE_DEPTH = bptb_pkg::QueueDepthDef,
  localparam int unsigned POS_W      = $clog2(MAX_LEN + 2)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [bptb_pkg::EnW-1:0] class_enable_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               symbol_i,
  input  logic                     last_symbol_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     item_kind_o,
  output logic [POS_W-1:0]         open_pos_o,
  output logic [POS_W-1:0]         close_pos_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  import bptb_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_LEN + 1);
  localparam int unsigned QW     = $bits(ctl_t) + POS_W;

  logic             q_full, q_push, q_valid, q_pop;
  ctl_t             f_ctl, b_ctl;
  logic [POS_W-1:0] f_pos, b_pos;

  bptb_front #(
    .MAX_LEN (MAX_LEN),
    .POS_W   (POS_W)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .class_enable_i (class_enable_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .symbol_i       (symbol_i),
    .last_symbol_i  (last_symbol_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_ctl_o        (f_ctl),
    .q_pos_o        (f_pos)
  );

  bptb_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({f_ctl, f_pos}),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  ({b_ctl, b_pos}),
    .pop_i   (q_pop)
  );

  bptb_back #(
    .MAX_LEN (MAX_LEN),
    .POS_W   (POS_W),
    .ADDR_W  (ADDR_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ctl_i     (b_ctl),
    .q_pos_i     (b_pos),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .item_kind_o (item_kind_o),
    .open_pos_o  (open_pos_o),
    .close_pos_o (close_pos_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
